// ===== rtl/core/tcw_pkg.sv =====
// Package for the text console writer: command codes, input modes and the
// command word that travels from the front end to the back end through the queue.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_CURSOR = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [7:0] BYTE_LF       = 8'd10;
    localparam logic [7:0] BYTE_CR       = 8'd13;
    localparam logic [7:0] BYTE_PRINT_LO = 8'd32;
    localparam logic [7:0] BYTE_PRINT_HI = 8'd127;
    localparam logic [7:0] BYTE_COLOR_LO = 8'd240;

    localparam int CHAR_W  = 7;
    localparam int COLOR_W = 4;
    localparam int CELL_W  = CHAR_W + COLOR_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPW         = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CHAR,
        OP_NEWLINE,
        OP_COLOR,
        OP_CURSOR,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] chr;
        logic [7:0]        col;
        logic [7:0]        row;
    } t_cmd;

endpackage

// ===== rtl/core/tcw_front.sv =====
// Front end of the text console writer: takes input transactions, classifies
// them into commands and saturates the target coordinates. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_front #(
    parameter int COLUMNS = 128,
    parameter int ROWS    = 60
) (
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_mode,
    input  logic [7:0]    i_byte_value,
    input  logic [7:0]    i_target_col,
    input  logic [7:0]    i_target_row,
    input  logic          i_clearing,
    input  logic          i_queue_full,
    output logic          o_push,
    output tcw_pkg::t_cmd o_cmd
);
    import tcw_pkg::*;

    assign o_in_stall = i_queue_full | i_clearing;
    assign o_push     = i_in_valid & ~o_in_stall;

    always_comb begin
        o_cmd.chr = i_byte_value[CHAR_W-1:0];
        o_cmd.col = ({1'b0, i_target_col} >= 9'(COLUMNS)) ? 8'(COLUMNS - 1) : i_target_col;
        o_cmd.row = ({1'b0, i_target_row} >= 9'(ROWS)) ? 8'(ROWS - 1) : i_target_row;
        case (i_mode)
            MODE_WRITE: begin
                if (i_byte_value inside {[BYTE_PRINT_LO:BYTE_PRINT_HI]}) begin
                    o_cmd.op = OP_CHAR;
                end else if (i_byte_value == BYTE_LF || i_byte_value == BYTE_CR) begin
                    o_cmd.op = OP_NEWLINE;
                end else if (i_byte_value >= BYTE_COLOR_LO) begin
                    o_cmd.op = OP_COLOR;
                end else begin
                    o_cmd.op = OP_NOP;
                end
            end
            MODE_CURSOR: o_cmd.op = OP_CURSOR;
            MODE_READ:   o_cmd.op = OP_READ;
            default:     o_cmd.op = OP_NOP;
        endcase
    end

endmodule

// ===== rtl/core/tcw_queue.sv =====
// Short command queue between the front end and the back end of the text
// console writer. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcw_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tcw_pkg::t_cmd o_cmd
);
    import tcw_pkg::*;

    t_cmd           r_data [QUEUE_DEPTH];
    logic [QPW-1:0] r_wp;
    logic [QPW-1:0] r_rp;
    logic [QPW:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (QPW + 1)'(QUEUE_DEPTH));
    assign o_cmd   = r_data[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/tcw_back.sv =====
// Back end of the text console writer: cursor and pen state, the cell memory
// with its row ring, the reset clearing pass, the scroll row copy and the
// output register. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_back #(
    parameter int COLUMNS = 128,
    parameter int ROWS    = 60
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  tcw_pkg::t_cmd               i_q_cmd,
    output logic                        o_pop,
    output logic                        o_clearing,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [tcw_pkg::CHAR_W-1:0]  o_read_char,
    output logic [tcw_pkg::COLOR_W-1:0] o_read_color,
    output logic [$clog2(COLUMNS)-1:0]  o_at_col,
    output logic [$clog2(ROWS)-1:0]     o_at_row,
    output logic [tcw_pkg::COLOR_W-1:0] o_pen_color
);
    import tcw_pkg::*;

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (2 ** CW);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_RUN,
        S_READ,
        S_COPY
    } t_state;

    t_state             r_state,      n_state;
    logic [CW-1:0]      r_col,        n_col;
    logic [RW-1:0]      r_row,        n_row;
    logic [COLOR_W-1:0] r_color,      n_color;
    logic [RW-1:0]      r_base,       n_base;
    logic [RW-1:0]      r_src,        n_src;
    logic [CW:0]        r_k,          n_k;
    logic [CW-1:0]      r_clr_col,    n_clr_col;
    logic [RW-1:0]      r_clr_row,    n_clr_row;
    logic               r_out_valid,  n_out_valid;
    logic [CHAR_W-1:0]  r_read_char,  n_read_char;
    logic [COLOR_W-1:0] r_read_color, n_read_color;
    logic [CW-1:0]      r_at_col,     n_at_col;
    logic [RW-1:0]      r_at_row,     n_at_row;
    logic [COLOR_W-1:0] r_pen_color,  n_pen_color;

    logic [CELL_W-1:0]  r_mem [DEPTH];
    logic [CELL_W-1:0]  r_rd;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic [AW-1:0]      mem_raddr;

    logic               slot_free;
    logic [RW:0]        cur_sum;
    logic [RW-1:0]      cur_phys;
    logic [RW:0]        cmd_sum;
    logic [RW-1:0]      cmd_phys;
    logic [CW:0]        col_inc;
    logic [RW:0]        row_inc;
    logic [CW:0]        k_dec;
    logic               adv_row;
    logic               scroll;
    logic               emit;
    logic [CW-1:0]      nc;
    logic [RW-1:0]      nr;

    assign slot_free   = ~r_out_valid | ~i_out_stall;
    assign o_clearing  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_read_char  = r_read_char;
    assign o_read_color = r_read_color;
    assign o_at_col     = r_at_col;
    assign o_at_row     = r_at_row;
    assign o_pen_color  = r_pen_color;

    assign cur_sum  = {1'b0, r_row} + {1'b0, r_base};
    assign cur_phys = (cur_sum >= (RW + 1)'(ROWS)) ? RW'(cur_sum - (RW + 1)'(ROWS))
                                                   : cur_sum[RW-1:0];
    assign cmd_sum  = {1'b0, i_q_cmd.row[RW-1:0]} + {1'b0, r_base};
    assign cmd_phys = (cmd_sum >= (RW + 1)'(ROWS)) ? RW'(cmd_sum - (RW + 1)'(ROWS))
                                                   : cmd_sum[RW-1:0];
    assign col_inc  = {1'b0, r_col} + (CW + 1)'(1);
    assign row_inc  = {1'b0, r_row} + (RW + 1)'(1);
    assign k_dec    = r_k - (CW + 1)'(1);

    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        n_color      = r_color;
        n_base       = r_base;
        n_src        = r_src;
        n_k          = r_k;
        n_clr_col    = r_clr_col;
        n_clr_row    = r_clr_row;
        n_out_valid  = r_out_valid & i_out_stall;
        n_read_char  = r_read_char;
        n_read_color = r_read_color;
        n_at_col     = r_at_col;
        n_at_row     = r_at_row;
        n_pen_color  = r_pen_color;
        o_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = {cur_phys, r_col};
        mem_wdata    = {i_q_cmd.chr, r_color};
        mem_raddr    = {cmd_phys, i_q_cmd.col[CW-1:0]};
        adv_row      = 1'b0;
        scroll       = 1'b0;
        emit         = 1'b0;
        nc           = r_col;
        nr           = r_row;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = {r_clr_row, r_clr_col};
                mem_wdata = '0;
                n_clr_col = r_clr_col + 1'b1;
                if (r_clr_col == '1) begin
                    n_clr_row = r_clr_row + 1'b1;
                    if (r_clr_row == RW'(ROWS - 1)) begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (i_q_valid && slot_free) begin
                    o_pop = 1'b1;
                    case (i_q_cmd.op)
                        OP_CHAR: begin
                            mem_we = 1'b1;
                            if (col_inc == (CW + 1)'(COLUMNS)) begin
                                nc      = '0;
                                adv_row = 1'b1;
                            end else begin
                                nc = col_inc[CW-1:0];
                            end
                        end
                        OP_NEWLINE: begin
                            nc      = '0;
                            adv_row = 1'b1;
                        end
                        OP_COLOR: begin
                            n_color = i_q_cmd.chr[COLOR_W-1:0];
                        end
                        OP_CURSOR: begin
                            nc = i_q_cmd.col[CW-1:0];
                            nr = i_q_cmd.row[RW-1:0];
                        end
                        OP_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                        end
                    endcase
                    if (adv_row) begin
                        if (row_inc == (RW + 1)'(ROWS)) begin
                            scroll = 1'b1;
                        end else begin
                            nr = row_inc[RW-1:0];
                        end
                    end
                    n_col = nc;
                    n_row = nr;
                    if (scroll) begin
                        n_state = S_COPY;
                        n_k     = '0;
                        n_src   = (r_base == '0) ? RW'(ROWS - 1) : r_base - 1'b1;
                    end else if (i_q_cmd.op != OP_READ) begin
                        emit = 1'b1;
                    end
                end
            end
            S_READ: begin
                n_state      = S_RUN;
                n_out_valid  = 1'b1;
                n_read_char  = r_rd[CELL_W-1:COLOR_W];
                n_read_color = r_rd[COLOR_W-1:0];
                n_at_col     = r_col;
                n_at_row     = r_row;
                n_pen_color  = r_color;
            end
            S_COPY: begin
                mem_raddr = {r_src, r_k[CW-1:0]};
                mem_waddr = {r_base, k_dec[CW-1:0]};
                mem_wdata = r_rd;
                mem_we    = (r_k != '0);
                n_k       = r_k + 1'b1;
                if (r_k == (CW + 1)'(COLUMNS)) begin
                    n_state = S_RUN;
                    n_base  = (r_base == RW'(ROWS - 1)) ? '0 : r_base + 1'b1;
                    emit    = 1'b1;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase

        if (emit) begin
            n_out_valid  = 1'b1;
            n_read_char  = '0;
            n_read_color = '0;
            n_at_col     = n_col;
            n_at_row     = n_row;
            n_pen_color  = n_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_col       <= '0;
            r_row       <= '0;
            r_color     <= '0;
            r_base      <= '0;
            r_src       <= '0;
            r_k         <= '0;
            r_clr_col   <= '0;
            r_clr_row   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_col        <= n_col;
            r_row        <= n_row;
            r_color      <= n_color;
            r_base       <= n_base;
            r_src        <= n_src;
            r_k          <= n_k;
            r_clr_col    <= n_clr_col;
            r_clr_row    <= n_clr_row;
            r_out_valid  <= n_out_valid;
            r_read_char  <= n_read_char;
            r_read_color <= n_read_color;
            r_at_col     <= n_at_col;
            r_at_row     <= n_at_row;
            r_pen_color  <= n_pen_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

endmodule

// ===== rtl/core/text_console_writer_core.sv =====
// An accepted transaction passes the queue and the output register; a cell read also
// passes S_READ, and a line feed or wrap that scrolls runs S_COPY first (one cell memory
// port pair copies the last row into the recycled row, one column per cycle).
// Throughput: one transaction per cycle for writes, colors and cursor moves, while no
// stall or scroll holds them; a read also holds S_READ. Reset is synchronous; a clearing
// pass then zeroes the ROWS * 2^ceil(log2 COLUMNS) cells (7680 by default), input stalled.
`timescale 1ns / 1ps

module text_console_writer_core #(
    parameter int COLUMNS = 128,
    parameter int ROWS    = 60
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_mode,
    input  logic [7:0]                  i_byte_value,
    input  logic [7:0]                  i_target_col,
    input  logic [7:0]                  i_target_row,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [tcw_pkg::CHAR_W-1:0]  o_read_char,
    output logic [tcw_pkg::COLOR_W-1:0] o_read_color,
    output logic [$clog2(COLUMNS)-1:0]  o_at_col,
    output logic [$clog2(ROWS)-1:0]     o_at_row,
    output logic [tcw_pkg::COLOR_W-1:0] o_pen_color
);
    import tcw_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_valid;
    logic clearing;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_byte_value (i_byte_value),
        .i_target_col (i_target_col),
        .i_target_row (i_target_row),
        .i_clearing   (clearing),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (queue_valid),
        .i_q_cmd      (queue_cmd),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_char  (o_read_char),
        .o_read_color (o_read_color),
        .o_at_col     (o_at_col),
        .o_at_row     (o_at_row),
        .o_pen_color  (o_pen_color)
    );

endmodule

// ===== rtl/core/tcw_checker.sv =====
// Port-level checks for the text console writer, attached to the top level by
// the bind statement at the end of this file. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_checker #(
    parameter int COLUMNS = 128,
    parameter int ROWS    = 60
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [tcw_pkg::CHAR_W-1:0]  o_read_char,
    input logic [tcw_pkg::COLOR_W-1:0] o_read_color,
    input logic [$clog2(COLUMNS)-1:0]  o_at_col,
    input logic [$clog2(ROWS)-1:0]     o_at_row,
    input logic [tcw_pkg::COLOR_W-1:0] o_pen_color
);

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_at_row) < ROWS))
        else $error("Reported cursor row is beyond the last row.");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_at_col) < COLUMNS))
        else $error("Reported cursor column is beyond the last column.");

    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !$past(i_rst_n)) |-> o_in_stall)
        else $error("Input was not stalled while the cell memory is being cleared.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_read_char)
            && $stable(o_read_color) && $stable(o_at_col) && $stable(o_at_row)
            && $stable(o_pen_color)))
        else $error("A stalled result transaction changed or was dropped.");

endmodule

bind text_console_writer_core tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_read_char  (o_read_char),
    .o_read_color (o_read_color),
    .o_at_col     (o_at_col),
    .o_at_row     (o_at_row),
    .o_pen_color  (o_pen_color)
);
